// ===== rtl/stqw_pkg.sv =====
package stqw_pkg;

  // Default width of the byte position inside a table.
  localparam int POSITION_BITS_DEF = 16;

  localparam logic [7:0] STOP_TYPE  = 8'd127;
  localparam logic [7:0] MIN_LENGTH = 8'd4;

  // Query modes.
  localparam logic [1:0] MODE_COUNT  = 2'd0;
  localparam logic [1:0] MODE_WORD   = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_QUERY_MODE     = 3'd0;
  localparam logic [2:0] REG_STRUCT_TYPE    = 3'd1;
  localparam logic [2:0] REG_FIELD_OFFSET   = 3'd2;
  localparam logic [2:0] REG_INSTANCE_INDEX = 3'd3;
  localparam logic [2:0] REG_TABLE_LENGTH   = 3'd4;

  // Result kinds.
  localparam logic KIND_STRING_BYTE = 1'b0;
  localparam logic KIND_FINAL       = 1'b1;

  typedef enum logic [6:0] {
    PH_TYPE      = 7'b0000001,
    PH_LEN       = 7'b0000010,
    PH_FMT       = 7'b0000100,
    PH_STR_START = 7'b0001000,
    PH_IN_STR    = 7'b0010000,
    PH_STREAM    = 7'b0100000,
    PH_DONE      = 7'b1000000
  } phase_t;

  // Outcome of looking at one formatted-area byte of the queried structure.
  typedef struct packed {
    logic        fin;
    logic [15:0] cap;
    logic [15:0] value;
    logic        found;
  } field_t;

  function automatic field_t take_field(input logic on_target, input logic [1:0] mode,
                                        input logic eq0, input logic eq1,
                                        input logic [7:0] b, input logic [15:0] cap);
    field_t f;
    f.fin   = 1'b0;
    f.cap   = cap;
    f.value = 16'd0;
    f.found = 1'b0;
    if (on_target) begin
      if (mode == MODE_WORD) begin
        if (eq0) f.cap = {8'd0, b};
        if (eq1) begin
          f.cap   = {b, f.cap[7:0]};
          f.fin   = 1'b1;
          f.value = f.cap;
          f.found = 1'b1;
        end
      end else if (mode == MODE_STRING && eq0) begin
        f.cap = {8'd0, b};
        if (b == 8'd0) f.fin = 1'b1;
      end
    end
    return f;
  endfunction

endpackage

// ===== rtl/smbios_table_query_walker.sv =====
// Structure table query walker.
//
// The input channel (in_*) carries the table one byte per beat. The block
// walks the structures (type byte, length byte, formatted area, string set)
// and answers the query set up through the configuration port (cfg_*):
// the count of structures of a type, the little-endian word at an offset in
// the selected instance, or the string picked by the index byte there.
// In string mode each byte of the string leaves as a beat with out_tuser low,
// followed by a final beat with out_tuser and out_tlast high. Every table run
// ends with exactly one final beat, given as soon as the answer is known or
// at the byte at position table_length-1, after which the walk restarts.
//
// Each accepted byte is decoded combinationally; its result, if any, is in the
// output register on the next cycle. One byte is accepted per cycle for as
// long as the receiver keeps up: the single output register holds a waiting
// result, and in_tready drops only while that register is full and
// out_tready is low, so a stalled receiver stalls the input with no loss.
// The synchronous reset loads the register defaults, empties the output
// register and puts the walk at position zero expecting a type byte.
// The user must write configuration only while no beat is in flight; not enforced.
module smbios_table_query_walker #(
  parameter int POSITION_BITS = stqw_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] table_byte
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] data_value, [16] found, zero fill above
  output logic        out_tuser,  // [0] result_kind
  output logic        out_tlast,  // last
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;

  // Configuration registers.
  logic [1:0]  query_mode_r;
  logic [7:0]  struct_type_r;
  logic [7:0]  field_offset_r;
  logic [15:0] instance_index_r;
  logic [15:0] table_length_r;

  // Walk state.
  logic [POSITION_BITS-1:0] byte_position_r, byte_position_nxt;
  logic [POSITION_BITS-1:0] struct_start_r, struct_start_nxt;
  stqw_pkg::phase_t         walk_phase_r, walk_phase_nxt;
  logic [7:0]               current_type_r, current_type_nxt;
  logic [7:0]               formatted_length_r, formatted_length_nxt;
  logic [15:0]              match_count_r, match_count_nxt;
  logic [15:0]              captured_field_r, captured_field_nxt;
  logic [7:0]               string_counter_r, string_counter_nxt;
  logic                     previous_was_zero_r, previous_was_zero_nxt;
  logic                     answer_given_r, answer_given_nxt;
  logic                     on_target_r, on_target_nxt;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_value_r;
  logic        out_found_r;
  logic        out_kind_r;

  // Result of the current byte.
  logic        res_v;
  logic        res_kind;
  logic [15:0] res_value;
  logic        res_found;

  logic                     accept;
  logic [7:0]               b;
  logic [15:0]              len_total;
  logic [CW-1:0]            pos_ext, len_ext, pos_p1, r_ext, off_ext;
  logic [POSITION_BITS-1:0] r_pos;
  logic [8:0]               off_p1;
  logic                     stringq;
  stqw_pkg::field_t         f0, f1, ff;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;

  assign len_total = (table_length_r == 16'd0) ? 16'd1 : table_length_r;
  assign pos_ext   = CW'(byte_position_r);
  assign len_ext   = CW'(len_total);
  assign pos_p1    = pos_ext + CW'(1);
  assign r_pos     = byte_position_r - struct_start_r;
  assign r_ext     = CW'(r_pos);
  assign off_ext   = CW'(field_offset_r);
  assign off_p1    = {1'b0, field_offset_r} + 9'd1;
  assign stringq   = on_target_r && (query_mode_r == stqw_pkg::MODE_STRING);

  always_comb begin
    walk_phase_nxt        = walk_phase_r;
    struct_start_nxt      = struct_start_r;
    current_type_nxt      = current_type_r;
    formatted_length_nxt  = formatted_length_r;
    match_count_nxt       = match_count_r;
    captured_field_nxt    = captured_field_r;
    string_counter_nxt    = string_counter_r;
    previous_was_zero_nxt = previous_was_zero_r;
    answer_given_nxt      = answer_given_r;
    on_target_nxt         = on_target_r;
    byte_position_nxt     = byte_position_r;
    res_v     = 1'b0;
    res_kind  = stqw_pkg::KIND_FINAL;
    res_value = 16'd0;
    res_found = 1'b0;
    f0 = '0;
    f1 = '0;
    ff = '0;

    unique case (walk_phase_r)
      stqw_pkg::PH_TYPE: begin
        current_type_nxt = b;
        if (b == stqw_pkg::STOP_TYPE || (pos_ext + CW'(4)) > len_ext) begin
          res_v     = 1'b1;
          res_value = (query_mode_r == stqw_pkg::MODE_COUNT) ? match_count_r : 16'd0;
          res_found = (query_mode_r == stqw_pkg::MODE_COUNT);
        end else begin
          walk_phase_nxt = stqw_pkg::PH_LEN;
        end
      end
      stqw_pkg::PH_LEN: begin
        formatted_length_nxt = b;
        if (b < stqw_pkg::MIN_LENGTH || (CW'(struct_start_r) + CW'(b)) > len_ext) begin
          res_v     = 1'b1;
          res_value = (query_mode_r == stqw_pkg::MODE_COUNT) ? match_count_r : 16'd0;
          res_found = (query_mode_r == stqw_pkg::MODE_COUNT);
        end else begin
          on_target_nxt = 1'b0;
          if (current_type_r == struct_type_r) begin
            if (query_mode_r == stqw_pkg::MODE_COUNT) begin
              if (match_count_r != 16'hFFFF) match_count_nxt = match_count_r + 16'd1;
            end else if (query_mode_r == stqw_pkg::MODE_WORD ||
                         query_mode_r == stqw_pkg::MODE_STRING) begin
              if (match_count_r == instance_index_r) begin
                on_target_nxt = 1'b1;
                // Offset must fall inside the formatted area, checked without wrap.
                if ((query_mode_r == stqw_pkg::MODE_WORD && off_p1 >= {1'b0, b}) ||
                    (query_mode_r == stqw_pkg::MODE_STRING && field_offset_r >= b)) begin
                  res_v = 1'b1;
                end
              end else if (match_count_r != 16'hFFFF) begin
                match_count_nxt = match_count_r + 16'd1;
              end
            end
          end
          if (!res_v) begin
            walk_phase_nxt = stqw_pkg::PH_FMT;
            // The header bytes are offsets zero and one of the structure.
            f0 = stqw_pkg::take_field(on_target_nxt, query_mode_r,
                                      field_offset_r == 8'd0, 1'b0,
                                      current_type_r, captured_field_r);
            captured_field_nxt = f0.cap;
            if (f0.fin) begin
              res_v     = 1'b1;
              res_value = f0.value;
              res_found = f0.found;
            end else begin
              f1 = stqw_pkg::take_field(on_target_nxt, query_mode_r,
                                        field_offset_r == 8'd1, field_offset_r == 8'd0,
                                        b, f0.cap);
              captured_field_nxt = f1.cap;
              if (f1.fin) begin
                res_v     = 1'b1;
                res_value = f1.value;
                res_found = f1.found;
              end
            end
          end
        end
      end
      stqw_pkg::PH_FMT: begin
        ff = stqw_pkg::take_field(on_target_r, query_mode_r,
                                  r_ext == off_ext, r_ext == (off_ext + CW'(1)),
                                  b, captured_field_r);
        captured_field_nxt = ff.cap;
        if (ff.fin) begin
          res_v     = 1'b1;
          res_value = ff.value;
          res_found = ff.found;
        end else if ((r_ext + CW'(1)) >= CW'(formatted_length_r)) begin
          walk_phase_nxt        = stqw_pkg::PH_STR_START;
          previous_was_zero_nxt = 1'b0;
          string_counter_nxt    = 8'd1;
        end
      end
      stqw_pkg::PH_STR_START: begin
        if (b == 8'd0) begin
          if (stringq) begin
            res_v = 1'b1;
          end else if (previous_was_zero_r) begin
            walk_phase_nxt   = stqw_pkg::PH_TYPE;
            struct_start_nxt = byte_position_r + POSITION_BITS'(1);
          end else begin
            previous_was_zero_nxt = 1'b1;
          end
        end else begin
          previous_was_zero_nxt = 1'b0;
          if (stringq && {8'd0, string_counter_r} == captured_field_r) begin
            walk_phase_nxt = stqw_pkg::PH_STREAM;
            res_v     = 1'b1;
            res_kind  = stqw_pkg::KIND_STRING_BYTE;
            res_value = {8'd0, b};
            res_found = 1'b1;
          end else begin
            walk_phase_nxt = stqw_pkg::PH_IN_STR;
          end
        end
      end
      stqw_pkg::PH_IN_STR: begin
        if (b == 8'd0) begin
          previous_was_zero_nxt = 1'b1;
          walk_phase_nxt        = stqw_pkg::PH_STR_START;
          if (string_counter_r != 8'hFF) string_counter_nxt = string_counter_r + 8'd1;
        end else begin
          previous_was_zero_nxt = 1'b0;
        end
      end
      stqw_pkg::PH_STREAM: begin
        res_v     = 1'b1;
        res_found = 1'b1;
        if (b == 8'd0) begin
          res_value = captured_field_r;
        end else begin
          res_kind  = stqw_pkg::KIND_STRING_BYTE;
          res_value = {8'd0, b};
        end
      end
      stqw_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    // A final answer closes the walk for the rest of the table.
    if (res_v && res_kind == stqw_pkg::KIND_FINAL) begin
      answer_given_nxt = 1'b1;
      walk_phase_nxt   = stqw_pkg::PH_DONE;
    end

    // Last byte of the table: close the run and restart at position zero.
    if (pos_p1 >= len_ext) begin
      if (res_v && res_kind == stqw_pkg::KIND_STRING_BYTE) begin
        // String cut off by the table end: not found.
        res_kind  = stqw_pkg::KIND_FINAL;
        res_value = 16'd0;
        res_found = 1'b0;
      end else if (!res_v && !answer_given_r) begin
        res_v     = 1'b1;
        res_kind  = stqw_pkg::KIND_FINAL;
        res_value = (query_mode_r == stqw_pkg::MODE_COUNT) ? match_count_nxt : 16'd0;
        res_found = (query_mode_r == stqw_pkg::MODE_COUNT);
      end
      walk_phase_nxt        = stqw_pkg::PH_TYPE;
      struct_start_nxt      = '0;
      current_type_nxt      = 8'd0;
      formatted_length_nxt  = 8'd0;
      match_count_nxt       = 16'd0;
      captured_field_nxt    = 16'd0;
      string_counter_nxt    = 8'd1;
      previous_was_zero_nxt = 1'b0;
      answer_given_nxt      = 1'b0;
      on_target_nxt         = 1'b0;
      byte_position_nxt     = '0;
    end else begin
      byte_position_nxt = byte_position_r + POSITION_BITS'(1);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_mode_r     <= stqw_pkg::MODE_COUNT;
      struct_type_r    <= 8'd17;
      field_offset_r   <= 8'd0;
      instance_index_r <= 16'd0;
      table_length_r   <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        stqw_pkg::REG_QUERY_MODE:     query_mode_r     <= cfg_wdata[1:0];
        stqw_pkg::REG_STRUCT_TYPE:    struct_type_r    <= cfg_wdata[7:0];
        stqw_pkg::REG_FIELD_OFFSET:   field_offset_r   <= cfg_wdata[7:0];
        stqw_pkg::REG_INSTANCE_INDEX: instance_index_r <= cfg_wdata;
        stqw_pkg::REG_TABLE_LENGTH:   table_length_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Walk state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r     <= '0;
      struct_start_r      <= '0;
      walk_phase_r        <= stqw_pkg::PH_TYPE;
      current_type_r      <= 8'd0;
      formatted_length_r  <= 8'd0;
      match_count_r       <= 16'd0;
      captured_field_r    <= 16'd0;
      string_counter_r    <= 8'd1;
      previous_was_zero_r <= 1'b0;
      answer_given_r      <= 1'b0;
      on_target_r         <= 1'b0;
    end else if (accept) begin
      byte_position_r     <= byte_position_nxt;
      struct_start_r      <= struct_start_nxt;
      walk_phase_r        <= walk_phase_nxt;
      current_type_r      <= current_type_nxt;
      formatted_length_r  <= formatted_length_nxt;
      match_count_r       <= match_count_nxt;
      captured_field_r    <= captured_field_nxt;
      string_counter_r    <= string_counter_nxt;
      previous_was_zero_r <= previous_was_zero_nxt;
      answer_given_r      <= answer_given_nxt;
      on_target_r         <= on_target_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res_v;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value_r <= res_value;
      out_found_r <= res_found;
      out_kind_r  <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_found_r, out_value_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = (out_kind_r == stqw_pkg::KIND_FINAL);

endmodule

// ===== rtl/stqw_checker.sv =====
module stqw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A reset leaves the result channel empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat present after reset");

  // The input is held back only by a waiting result.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled with no waiting result");

  // A stalled result beat stays unchanged.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result beat changed");

  // String bytes are found and never close the run; final beats always do.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == out_tlast) && (out_tuser || out_tdata[16])))
    else $error("result kind and last disagree");

  // A not-found answer carries zero.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[16]) |-> (out_tdata[15:0] == 16'd0))
    else $error("not-found answer carries data");

endmodule

bind smbios_table_query_walker stqw_checker u_stqw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ===== sim/smbios_table_query_walker_tb.sv =====
`timescale 1ns / 1ps

module smbios_table_query_walker_tb;

  // The package names modes 0 to 2 only; the fourth encoding selects nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Random stimulus length in table bytes, the settle time granted to the
  // block before a register write or the final verdict, and the watchdog.
  localparam int unsigned RANDOM_BYTES = 900;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One result beat as the table walk predicts it.
  typedef struct packed {
    logic        kind;
    logic [15:0] value;
    logic        found;
    logic        last;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  // Table bytes waiting to be sent; the head is the one on the bus.
  logic [7:0]  byte_q[$];
  // Results the walk has predicted but the block has not yet delivered.
  answer_t     answer_q[$];
  // Scratch area where whole structures are assembled before sending.
  logic [7:0]  shape_q[$];

  int unsigned fails = 0;
  int unsigned cycles = 0;
  logic        took_beat = 1'b0;
  logic        steady = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic        sink_busy = 1'b0;
  int unsigned sink_left = 0;

  // Shadow copy of the query registers.
  logic [1:0]  q_mode;
  logic [7:0]  q_type;
  logic [7:0]  q_offset;
  logic [15:0] q_instance;
  logic [15:0] q_length;

  // Walk state of the predictor.
  logic [15:0]      w_pos;
  logic [15:0]      w_start;
  stqw_pkg::phase_t w_phase;
  logic [7:0]       w_type;
  logic [7:0]       w_flen;
  logic [7:0]       w_strno;
  logic [15:0]      w_matches;
  logic [15:0]      w_field;
  logic             w_prev_zero;
  logic             w_answered;
  logic             w_target;

  smbios_table_query_walker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Table walk predictor
  // ---------------------------------------------------------------------

  // Puts the walk back at the first structure of a new table run.
  function automatic void restart_walk();
    w_phase     = stqw_pkg::PH_TYPE;
    w_start     = 16'd0;
    w_type      = 8'd0;
    w_flen      = 8'd0;
    w_matches   = 16'd0;
    w_field     = 16'd0;
    w_strno     = 8'd1;
    w_prev_zero = 1'b0;
    w_answered  = 1'b0;
    w_target    = 1'b0;
  endfunction

  // Closes the run with its one final answer; the rest of the table is
  // ignored until the position wraps.
  function automatic answer_t close_run(input logic [15:0] value, input logic found);
    w_answered = 1'b1;
    w_phase    = stqw_pkg::PH_DONE;
    return '{stqw_pkg::KIND_FINAL, value, found, 1'b1};
  endfunction

  // A broken table ends the walk: count mode reports what it has counted,
  // the lookups report not found.
  function automatic answer_t stop_run();
    if (q_mode == stqw_pkg::MODE_COUNT) return close_run(w_matches, 1'b1);
    return close_run(16'd0, 1'b0);
  endfunction

  // Looks at one byte of the queried structure, at offset rel from its type
  // byte. A word is done at its high byte; a string index of zero is a miss.
  function automatic logic grab_field(input int unsigned rel, input logic [7:0] b,
                                      output answer_t a);
    a = '0;
    if (!w_target) return 1'b0;
    if (q_mode == stqw_pkg::MODE_WORD) begin
      if (rel == q_offset) w_field = {8'd0, b};
      if (rel == 32'(q_offset) + 1) begin
        w_field = {b, w_field[7:0]};
        a = close_run(w_field, 1'b1);
        return 1'b1;
      end
    end else if (q_mode == stqw_pkg::MODE_STRING && rel == q_offset) begin
      w_field = {8'd0, b};
      if (b == 8'd0) begin
        a = close_run(16'd0, 1'b0);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advances the walk by one accepted table byte and queues the result
  // beat it causes, if any.
  task automatic walk_byte(input logic [7:0] b);
    int unsigned len_total;
    int unsigned pos;
    logic [15:0] rel;
    logic        str_query;
    logic        got;
    answer_t     a;
    len_total = (q_length == 16'd0) ? 1 : q_length;
    pos       = 32'(w_pos);
    str_query = w_target && q_mode == stqw_pkg::MODE_STRING;
    got       = 1'b0;
    a         = '0;
    case (w_phase)
      stqw_pkg::PH_TYPE: begin
        w_type = b;
        // Type 127 ends the table, and so does a start with too few bytes left.
        if (b == stqw_pkg::STOP_TYPE || pos + 4 > len_total) begin
          a   = stop_run();
          got = 1'b1;
        end else begin
          w_phase = stqw_pkg::PH_LEN;
        end
      end
      stqw_pkg::PH_LEN: begin
        w_flen = b;
        if (b < stqw_pkg::MIN_LENGTH || w_start + b > len_total) begin
          a   = stop_run();
          got = 1'b1;
        end else begin
          w_target = 1'b0;
          if (w_type == q_type) begin
            if (q_mode == stqw_pkg::MODE_COUNT) begin
              if (w_matches != 16'hFFFF) w_matches++;
            end else if (q_mode == stqw_pkg::MODE_WORD ||
                         q_mode == stqw_pkg::MODE_STRING) begin
              if (w_matches == q_instance) begin
                w_target = 1'b1;
                // The offset test is done without 8-bit wrap.
                if ((q_mode == stqw_pkg::MODE_WORD && 32'(q_offset) + 1 >= b) ||
                    (q_mode == stqw_pkg::MODE_STRING && q_offset >= b)) begin
                  a   = close_run(16'd0, 1'b0);
                  got = 1'b1;
                end
              end else if (w_matches != 16'hFFFF) begin
                w_matches++;
              end
            end
          end
          if (!got) begin
            w_phase = stqw_pkg::PH_FMT;
            // Offsets 0 and 1 address the header bytes themselves.
            got = grab_field(0, w_type, a);
            if (!got) got = grab_field(1, b, a);
          end
        end
      end
      stqw_pkg::PH_FMT: begin
        rel = w_pos - w_start;
        got = grab_field(32'(rel), b, a);
        if (w_phase == stqw_pkg::PH_FMT && rel + 1 >= w_flen) begin
          w_phase     = stqw_pkg::PH_STR_START;
          w_prev_zero = 1'b0;
          w_strno     = 8'd1;
        end
      end
      stqw_pkg::PH_STR_START: begin
        if (b == 8'd0) begin
          if (str_query) begin
            // The set closed before the selected string turned up.
            a   = close_run(16'd0, 1'b0);
            got = 1'b1;
          end else if (w_prev_zero) begin
            w_phase = stqw_pkg::PH_TYPE;
            w_start = w_pos + 16'd1;
          end else begin
            w_prev_zero = 1'b1;
          end
        end else begin
          w_prev_zero = 1'b0;
          if (str_query && {8'd0, w_strno} == w_field) begin
            w_phase = stqw_pkg::PH_STREAM;
            a       = '{stqw_pkg::KIND_STRING_BYTE, {8'd0, b}, 1'b1, 1'b0};
            got     = 1'b1;
          end else begin
            w_phase = stqw_pkg::PH_IN_STR;
          end
        end
      end
      stqw_pkg::PH_IN_STR: begin
        if (b == 8'd0) begin
          w_prev_zero = 1'b1;
          w_phase     = stqw_pkg::PH_STR_START;
          if (w_strno != 8'hFF) w_strno++;
        end else begin
          w_prev_zero = 1'b0;
        end
      end
      stqw_pkg::PH_STREAM: begin
        if (b == 8'd0) begin
          a = close_run(w_field, 1'b1);
        end else begin
          a = '{stqw_pkg::KIND_STRING_BYTE, {8'd0, b}, 1'b1, 1'b0};
        end
        got = 1'b1;
      end
      default: begin
      end
    endcase
    // The byte at the end of the table always closes the run. A string cut
    // off by the table end is a miss, and its last byte is not passed on.
    if (pos + 1 >= len_total) begin
      if (got && a.kind == stqw_pkg::KIND_STRING_BYTE) begin
        a = close_run(16'd0, 1'b0);
      end else if (!got && !w_answered) begin
        a   = stop_run();
        got = 1'b1;
      end
      restart_walk();
      w_pos = 16'd0;
    end else begin
      w_pos = w_pos + 16'd1;
    end
    if (got) answer_q.insert(answer_q.size(), a);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Waits until every byte has been taken and every result has arrived, then
  // gives the block its settle time for a byte that caused no result.
  task automatic wait_drain();
    while (byte_q.size() != 0 || answer_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes one register and its shadow copy; the block is idle here, so no
  // byte is accepted between the two.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    case (idx)
      stqw_pkg::REG_QUERY_MODE:     q_mode = value[1:0];
      stqw_pkg::REG_STRUCT_TYPE:    q_type = value[7:0];
      stqw_pkg::REG_FIELD_OFFSET:   q_offset = value[7:0];
      stqw_pkg::REG_INSTANCE_INDEX: q_instance = value;
      stqw_pkg::REG_TABLE_LENGTH:   q_length = value;
      default: begin
      end
    endcase
  endtask

  // Sets up a new query once the block has gone quiet.
  task automatic set_query(input logic [1:0] mode, input logic [7:0] stype,
                           input logic [7:0] offset, input logic [15:0] inst,
                           input logic [15:0] tlen);
    wait_drain();
    write_reg(stqw_pkg::REG_QUERY_MODE, {14'd0, mode});
    write_reg(stqw_pkg::REG_STRUCT_TYPE, {8'd0, stype});
    write_reg(stqw_pkg::REG_FIELD_OFFSET, {8'd0, offset});
    write_reg(stqw_pkg::REG_INSTANCE_INDEX, inst);
    write_reg(stqw_pkg::REG_TABLE_LENGTH, tlen);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Assembles whole structures, at least n bytes of them. Most carry the
  // searched type; the byte at the queried offset is a string index that is
  // sometimes zero or past the last string. Now and then a stop type shows up.
  task automatic make_structs(input int unsigned n);
    int unsigned flen;
    int unsigned nstr;
    int unsigned i;
    logic [7:0]  stype;
    shape_q.delete();
    while (shape_q.size() < n) begin
      stype = ($urandom_range(0, 2) != 0) ? q_type : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 29) == 0) stype = stqw_pkg::STOP_TYPE;
      flen = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 40) : $urandom_range(4, 12);
      nstr = $urandom_range(0, 4);
      shape_q.insert(shape_q.size(), stype);
      shape_q.insert(shape_q.size(), 8'(flen));
      for (i = 2; i < flen; i++) begin
        if (i == q_offset) shape_q.insert(shape_q.size(), 8'($urandom_range(0, nstr + 1)));
        else shape_q.insert(shape_q.size(), 8'($urandom_range(0, 255)));
      end
      for (i = 0; i < nstr; i++) begin
        repeat ($urandom_range(1, 6)) shape_q.insert(shape_q.size(), 8'($urandom_range(1, 255)));
        shape_q.insert(shape_q.size(), 8'd0);
      end
      // An empty string set is still closed by a double zero.
      if (nstr == 0) shape_q.insert(shape_q.size(), 8'd0);
      shape_q.insert(shape_q.size(), 8'd0);
    end
  endtask

  // Queues one table run of exactly len bytes. Most runs are well formed but
  // cut at the table end wherever that falls; some carry one corrupted byte
  // and some are pure noise.
  task automatic send_table(input int unsigned len);
    int unsigned style;
    int unsigned i;
    style = $urandom_range(0, 9);
    make_structs(len);
    if (style == 1) shape_q[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
    for (i = 0; i < len; i++) begin
      if (style == 0) byte_q.insert(byte_q.size(), 8'($urandom_range(0, 255)));
      else byte_q.insert(byte_q.size(), shape_q[i]);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 9) return $urandom_range(1, 4);
    return $urandom_range(8, 20);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Clock, driver, receiver, monitor
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The sender presents table bytes in bursts of random length with random
  // gaps. A byte on the bus is held until its beat is taken; took_beat tells
  // whether the head of the queue moved on at the last rising edge.
  always @(negedge clk) begin
    if (in_tvalid && !took_beat) begin
      // Still waiting for the block to take the byte on the bus.
    end else if (gap_left != 0) begin
      in_tvalid <= 1'b0;
      gap_left--;
    end else if (byte_q.size() != 0) begin
      in_tvalid <= 1'b1;
      in_tdata  <= byte_q[0];
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap_left   = pick_gap();
      end
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // The receiver alternates runs of ready and stalled cycles of its own
  // random lengths; a steady phase keeps it ready throughout.
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_busy = !sink_busy;
      sink_left = sink_busy ? $urandom_range(1, 7) : $urandom_range(1, 30);
    end
    sink_left--;
    out_tready <= !(sink_busy && !steady);
  end

  // At each rising edge the accepted table byte is run through the predictor
  // first, then the result beat, if any, is checked against the oldest
  // prediction. This order holds even if a result could leave in the cycle of
  // its byte.
  always @(posedge clk) begin
    answer_t want;
    took_beat <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      walk_byte(in_tdata);
      void'(byte_q.pop_front());
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (answer_q.size() == 0) begin
        $error("result beat with nothing expected: data_value %0h, result_kind %0b",
               out_tdata[15:0], out_tuser);
        fails++;
      end else begin
        want = answer_q.pop_front();
        check_field("result_kind", 16'(want.kind), 16'(out_tuser));
        check_field("data_value", want.value, out_tdata[15:0]);
        check_field("found", 16'(want.found), 16'(out_tdata[16]));
        check_field("last", 16'(want.last), 16'(out_tlast));
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------

  initial begin
    int unsigned rand_bytes;
    int unsigned len_eff;
    int unsigned i;
    logic [1:0]  mode;
    logic [7:0]  stype;
    logic [7:0]  offset;
    logic [15:0] inst;
    logic [15:0] tlen;
    logic [7:0]  str_tab[16];
    logic [7:0]  word_tab[4];

    cfg_we    = 1'b0;
    cfg_addr  = stqw_pkg::REG_QUERY_MODE;
    cfg_wdata = 16'd0;
    rst_n     = 1'b0;
    rand_bytes = 0;

    // Register defaults after reset, and a walk at position zero.
    q_mode     = stqw_pkg::MODE_COUNT;
    q_type     = 8'd17;
    q_offset   = 8'd0;
    q_instance = 16'd0;
    q_length   = 16'd1;
    w_pos      = 16'd0;
    restart_walk();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. With the default one-byte table every byte is a whole
    // run too short for a structure, so each one closes with a count of zero.
    byte_q.insert(byte_q.size(), 8'hFF);
    byte_q.insert(byte_q.size(), 8'h00);
    byte_q.insert(byte_q.size(), stqw_pkg::STOP_TYPE);

    // A table length of zero behaves like a length of one.
    set_query(stqw_pkg::MODE_COUNT, 8'd17, 8'd0, 16'd0, 16'd0);
    byte_q.insert(byte_q.size(), 8'h5A);

    // String lookup: the index byte at offset 4 selects the second string,
    // whose two bytes stream out before the final answer carrying the index.
    set_query(stqw_pkg::MODE_STRING, 8'hFF, 8'd4, 16'd0, 16'd16);
    str_tab = '{8'hFF, 8'h05, 8'h00, 8'h00, 8'h02, 8'h78, 8'h00, 8'h81,
                8'h7F, 8'h00, 8'h00, 8'h00, stqw_pkg::STOP_TYPE, 8'h04, 8'h00, 8'h00};
    for (i = 0; i < 16; i++) byte_q.insert(byte_q.size(), str_tab[i]);

    // Word lookup at offset zero reads the type and length bytes themselves.
    set_query(stqw_pkg::MODE_WORD, 8'd17, 8'd0, 16'd0, 16'd4);
    word_tab = '{8'd17, 8'd4, 8'hEE, 8'h01};
    for (i = 0; i < 4; i++) byte_q.insert(byte_q.size(), word_tab[i]);

    // Random part: each setting gets a few table runs of its length.
    while (rand_bytes < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2: mode = stqw_pkg::MODE_COUNT;
        3, 4, 5: mode = stqw_pkg::MODE_WORD;
        6, 7, 8: mode = stqw_pkg::MODE_STRING;
        default: mode = MODE_UNUSED;
      endcase
      case ($urandom_range(0, 4))
        0: stype = 8'd0;
        1: stype = 8'hFF;
        2, 3: stype = 8'd17;
        default: stype = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0: offset = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom_range(0, 255));
        1: offset = 8'($urandom_range(0, 1));
        default: offset = 8'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 9))
        0: inst = 16'hFFFF;
        1: inst = 16'($urandom_range(0, 65535));
        default: inst = 16'($urandom_range(0, 2));
      endcase
      case ($urandom_range(0, 11))
        0: tlen = 16'($urandom_range(0, 3));
        1: tlen = 16'($urandom_range(4, 7));
        default: tlen = 16'($urandom_range(12, 120));
      endcase
      set_query(mode, stype, offset, inst, tlen);
      steady  = ($urandom_range(0, 5) == 0);
      len_eff = (tlen == 16'd0) ? 1 : 32'(tlen);
      repeat ($urandom_range(1, 4)) begin
        // Sometimes the sender holds back until every result is in.
        if ($urandom_range(0, 3) == 0) wait_drain();
        send_table(len_eff);
        rand_bytes += len_eff;
      end
    end
    steady = 1'b0;

    // Longest table: well-formed structures ended by a stop type, so the count
    // comes out early while the position is far into the table.
    set_query(stqw_pkg::MODE_COUNT, 8'd17, 8'd0, 16'd0, 16'hFFFF);
    make_structs(200);
    for (i = 0; i < shape_q.size(); i++) byte_q.insert(byte_q.size(), shape_q[i]);
    byte_q.insert(byte_q.size(), stqw_pkg::STOP_TYPE);

    // Shrinking the table now leaves the position beyond its end, so the
    // next byte counts as the last one and the walk starts over.
    set_query(stqw_pkg::MODE_COUNT, 8'd17, 8'd0, 16'd0, 16'd8);
    byte_q.insert(byte_q.size(), 8'h00);

    wait_drain();
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
